/* src/vtpy_pkg.sv */
// Shared constants, types and the arctangent table for the pitch/yaw pipeline.
// Used by vtpy_cordic and vector_to_pitch_yaw_core; no dependencies.
`default_nettype none
package vtpy_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int ITER          = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int CORDIC_LAT    = ITER + 1;

  localparam int IW  = 24;              // coordinate width
  localparam int DW  = IW + 1;          // delta width
  localparam int SQW = 2 * IW + 1;      // dx^2 + dy^2
  localparam int RW  = DW;              // root width
  localparam int SQRT_STAGES = RW;
  localparam int VW  = DW + 1;          // CORDIC operand width
  localparam int CW  = VW + 34;         // CORDIC datapath width (operand scaled by 2^30)
  localparam int AW  = 28;              // angle width, 1/65536 degree
  localparam int OW  = AW - 9;          // angle width, 1/128 degree

  localparam logic signed [AW-1:0] DEG_90  = AW'(90 * 65536);
  localparam logic signed [AW-1:0] DEG_180 = AW'(180 * 65536);
  localparam logic signed [AW-1:0] RND_HALF = AW'(256);
  localparam logic signed [OW-1:0] YAW_MAX  = OW'(23040);
  localparam logic signed [OW-1:0] YAW_SPAN = OW'(46080);

  localparam logic [13:0] PITCH_LIMIT_RST = 14'd11392;
  localparam logic [0:0]  REG_PITCH_LIMIT = 1'b0;

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } delta_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic signed [AW-1:0] v;
    begin
      case (i)
        0:  v = AW'(2949120);
        1:  v = AW'(1740967);
        2:  v = AW'(919879);
        3:  v = AW'(466945);
        4:  v = AW'(234379);
        5:  v = AW'(117304);
        6:  v = AW'(58666);
        7:  v = AW'(29335);
        8:  v = AW'(14668);
        9:  v = AW'(7334);
        10: v = AW'(3667);
        11: v = AW'(1833);
        12: v = AW'(917);
        13: v = AW'(458);
        14: v = AW'(229);
        15: v = AW'(115);
        16: v = AW'(57);
        17: v = AW'(29);
        18: v = AW'(14);
        19: v = AW'(7);
        20: v = AW'(4);
        21: v = AW'(2);
        22: v = AW'(1);
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

/* src/vtpy_cordic.sv */
// Pipelined CORDIC vectoring arctangent: atan2(y, x) in 1/65536 degree.
// One register stage for range reduction, one per iteration. Uses vtpy_pkg.
`default_nettype none
module vtpy_cordic (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [vtpy_pkg::VW-1:0]    y,
  input  wire logic signed [vtpy_pkg::VW-1:0]    x,
  output logic signed [vtpy_pkg::AW-1:0]         angle
);

  logic signed [vtpy_pkg::CW-1:0] xs [0:vtpy_pkg::ITER];
  logic signed [vtpy_pkg::CW-1:0] ys [0:vtpy_pkg::ITER];
  logic signed [vtpy_pkg::AW-1:0] zs [0:vtpy_pkg::ITER];
  logic                           sp [0:vtpy_pkg::ITER];

  logic signed [vtpy_pkg::VW-1:0] xn, yn;
  logic signed [vtpy_pkg::AW-1:0] z0;
  logic                           sp0;

  // fold the left half-plane onto the right, and catch exact axis directions
  always_comb begin
    xn  = x[vtpy_pkg::VW-1] ? -x : x;
    yn  = x[vtpy_pkg::VW-1] ? -y : y;
    sp0 = (y == '0) || (x == '0);
    if (y == '0) begin
      z0 = x[vtpy_pkg::VW-1] ? vtpy_pkg::DEG_180 : '0;
    end else if (x == '0) begin
      z0 = y[vtpy_pkg::VW-1] ? -vtpy_pkg::DEG_90 : vtpy_pkg::DEG_90;
    end else if (x[vtpy_pkg::VW-1]) begin
      z0 = y[vtpy_pkg::VW-1] ? -vtpy_pkg::DEG_180 : vtpy_pkg::DEG_180;
    end else begin
      z0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= {{(vtpy_pkg::CW-vtpy_pkg::VW-30){xn[vtpy_pkg::VW-1]}}, xn, 30'b0};
      ys[0] <= {{(vtpy_pkg::CW-vtpy_pkg::VW-30){yn[vtpy_pkg::VW-1]}}, yn, 30'b0};
      zs[0] <= z0;
      sp[0] <= sp0;
    end
  end

  for (genvar i = 0; i < vtpy_pkg::ITER; i++) begin : g_iter
    logic signed [vtpy_pkg::CW-1:0] xsh, ysh;
    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        sp[i+1] <= sp[i];
        if (sp[i]) begin
          xs[i+1] <= xs[i];
          ys[i+1] <= ys[i];
          zs[i+1] <= zs[i];
        end else if (!ys[i][vtpy_pkg::CW-1]) begin
          xs[i+1] <= xs[i] + ysh;
          ys[i+1] <= ys[i] - xsh;
          zs[i+1] <= zs[i] + vtpy_pkg::atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] - ysh;
          ys[i+1] <= ys[i] + xsh;
          zs[i+1] <= zs[i] - vtpy_pkg::atan_entry(i);
        end
      end
    end
  end

  assign angle = zs[vtpy_pkg::ITER];

endmodule
`default_nettype wire

/* src/vector_to_pitch_yaw_core.sv */
// Pitch and yaw from a source/target point pair; top level with APB register port.
// Depends on vtpy_pkg and vtpy_cordic.
// Registered stages in order: delta, square, sum, 25 square-root digit stages, the CORDIC
// stages, then round/clamp/wrap.
// Throughput: one beat per cycle; the whole pipeline holds while the output beat is stalled.
// Reset (rst, synchronous): clears all valid bits and sets pitch_limit to 89 degrees.
`default_nettype none
module vector_to_pitch_yaw_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // source_x, source_y, source_z, target_x, target_y, target_z (24 bits each)
  input  wire logic [143:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pitch_angle[14:0], yaw_angle[30:15], zero pad[31]
  output logic [31:0]       m_tdata,
  // degenerate
  output logic              m_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int DW  = vtpy_pkg::DW;
  localparam int SQW = vtpy_pkg::SQW;
  localparam int RW  = vtpy_pkg::RW;
  localparam int OW  = vtpy_pkg::OW;
  localparam int NSQ = vtpy_pkg::SQRT_STAGES;
  localparam int LAT = vtpy_pkg::CORDIC_LAT;

  logic        en;
  logic [13:0] pitch_limit;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_limit <= vtpy_pkg::PITCH_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == vtpy_pkg::REG_PITCH_LIMIT) begin
      pitch_limit <= pwdata[13:0];
    end
  end
  assign prdata = (paddr[2] == vtpy_pkg::REG_PITCH_LIMIT) ? {18'b0, pitch_limit} : 32'b0;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: deltas
  vtpy_pkg::delta_t d_in, d1, d2;
  logic v1, v2, v3;
  always_comb begin
    d_in.dx = DW'($signed(s_tdata[23:0]))   - DW'($signed(s_tdata[95:72]));
    d_in.dy = DW'($signed(s_tdata[47:24]))  - DW'($signed(s_tdata[119:96]));
    d_in.dz = DW'($signed(s_tdata[71:48]))  - DW'($signed(s_tdata[143:120]));
  end

  logic signed [2*DW-1:0] px, py;
  logic [SQW-2:0] sqx, sqy;
  assign px = d1.dx * d1.dx;
  assign py = d1.dy * d1.dy;

  // sqrt pipeline: index 0 is the sum stage
  logic                 sv    [0:NSQ];
  vtpy_pkg::delta_t     sd    [0:NSQ];
  logic [SQW-1:0]       srem  [0:NSQ];
  logic [RW-1:0]        sroot [0:NSQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end
  assign sv[0] = v3;

  always_ff @(posedge clk) begin
    if (en) begin
      d1       <= d_in;
      d2       <= d1;
      sqx      <= px[SQW-2:0];
      sqy      <= py[SQW-2:0];
      sd[0]    <= d2;
      srem[0]  <= {1'b0, sqx} + {1'b0, sqy};
      sroot[0] <= '0;
    end
  end

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam int K = NSQ - 1 - j;
    logic [SQW+1:0] trial, rem_x;
    assign rem_x = (SQW+2)'(srem[j]);
    assign trial = ((SQW+2)'(sroot[j]) << (K + 1)) + ((SQW+2)'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd[j+1] <= sd[j];
        if (rem_x >= trial) begin
          srem[j+1]  <= SQW'(rem_x - trial);
          sroot[j+1] <= sroot[j] | (RW'(1) << K);
        end else begin
          srem[j+1]  <= srem[j];
          sroot[j+1] <= sroot[j];
        end
      end
    end
  end

  // both arctangents in parallel
  vtpy_pkg::delta_t dq;
  logic signed [vtpy_pkg::AW-1:0] yaw_a, pitch_a;
  assign dq = sd[NSQ];

  vtpy_cordic u_yaw (
    .clk   (clk),
    .en    (en),
    .y     (vtpy_pkg::VW'(dq.dy)),
    .x     (vtpy_pkg::VW'(dq.dx)),
    .angle (yaw_a)
  );

  vtpy_cordic u_pitch (
    .clk   (clk),
    .en    (en),
    .y     (vtpy_pkg::VW'(dq.dz)),
    .x     ($signed({1'b0, sroot[NSQ]})),
    .angle (pitch_a)
  );

  // sideband alongside the CORDIC stages
  logic cv   [0:LAT];
  logic cdeg [0:LAT];
  logic cxp  [0:LAT];
  assign cv[0]   = sv[NSQ];
  assign cdeg[0] = (dq.dx == '0) && (dq.dy == '0) && (dq.dz == '0);
  assign cxp[0]  = !dq.dx[DW-1];

  for (genvar c = 0; c < LAT; c++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[c+1] <= 1'b0;
      end else if (en) begin
        cv[c+1] <= cv[c];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cdeg[c+1] <= cdeg[c];
        cxp[c+1]  <= cxp[c];
      end
    end
  end

  // round to 1/128 degree, wrap yaw, clamp pitch
  logic signed [vtpy_pkg::AW-1:0] yaw_full, yaw_rnd_a, pitch_rnd_a;
  logic signed [OW-1:0] yaw_r, yaw_w, pitch_r, pitch_n, lim, pitch_c;
  always_comb begin
    yaw_full    = yaw_a + (cxp[LAT] ? vtpy_pkg::DEG_180 : '0);
    yaw_rnd_a   = (yaw_full + vtpy_pkg::RND_HALF) >>> 9;
    yaw_r       = yaw_rnd_a[OW-1:0];
    if (yaw_r > vtpy_pkg::YAW_MAX) begin
      yaw_w = yaw_r - vtpy_pkg::YAW_SPAN;
    end else if (yaw_r < -vtpy_pkg::YAW_MAX) begin
      yaw_w = yaw_r + vtpy_pkg::YAW_SPAN;
    end else begin
      yaw_w = yaw_r;
    end
    pitch_rnd_a = (pitch_a + vtpy_pkg::RND_HALF) >>> 9;
    pitch_r     = pitch_rnd_a[OW-1:0];
    pitch_n     = -pitch_r;
    lim         = $signed({{(OW-14){1'b0}}, pitch_limit});
    if (pitch_n > lim) begin
      pitch_c = lim;
    end else if (pitch_n < -lim) begin
      pitch_c = -lim;
    end else begin
      pitch_c = pitch_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= cv[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= cdeg[LAT];
      if (cdeg[LAT]) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {1'b0, yaw_w[15:0], pitch_c[14:0]};
      end
    end
  end

endmodule
`default_nettype wire
